/* sv/cdd_pkg.sv */
// Shared types, constants and calendar helpers for the calendar day difference block.
package cdd_pkg;

    localparam int IN_YEAR_W  = 14;
    localparam int YEAR_W     = 15;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 15;
    localparam int REM_W      = 9;

    localparam logic [COUNT_W-1:0]   DAYS_CAP   = 15'd32767;
    localparam logic [IN_YEAR_W-1:0] MOD_BASE   = 14'd400;
    localparam logic [REM_W-1:0]     REM_LAST   = 9'd399;
    localparam logic [MONTH_W:0]     LAST_MONTH = 5'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic set_rem;
        logic advance;
    } step_ctrl_t;

    typedef struct packed {
        logic is_before;
        logic at_cap;
    } step_status_t;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } mod_status_t;

    // Months outside one to twelve count as 31 days long.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // True when the first date precedes the second, compared field by field.
    function automatic logic date_before(input logic [YEAR_W-1:0]  y1,
                                         input logic [MONTH_W-1:0] m1,
                                         input logic [DAY_W-1:0]   d1,
                                         input logic [YEAR_W-1:0]  y2,
                                         input logic [MONTH_W-1:0] m2,
                                         input logic [DAY_W-1:0]   d2);
        logic r;
        if (y1 != y2)
            r = (y1 < y2);
        else if (m1 != m2)
            r = (m1 < m2);
        else
            r = (d1 < d2);
        return r;
    endfunction

endpackage

/* sv/calendar_day_difference_top.sv */
// Top level of the calendar day difference block: sequencer, input and output handshakes.
//
// Each request carries a later and an earlier Gregorian date and yields one signed day count:
// zero for equal dates, -1 when the later date precedes the earlier one, and otherwise the
// number of days between them, saturating at 32767. After acceptance a request reduces the
// earlier year modulo 400 by repeated subtraction, then steps the earlier date one day at a
// time until the dates meet or the count saturates, then writes the result to the output
// register once that register is free. in_stall is high from acceptance until the result has
// been written to the output register; the next request may enter while that result waits.
module calendar_day_difference_top
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_YEAR_W-1:0] later_year,
    input  logic [MONTH_W-1:0]   later_month,
    input  logic [DAY_W-1:0]     later_day,
    input  logic [IN_YEAR_W-1:0] earlier_year,
    input  logic [MONTH_W-1:0]   earlier_month,
    input  logic [DAY_W-1:0]     earlier_day,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   days_between
);

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [15:0]  out_data_reg, out_data_next;

    logic                in_fire;
    logic                mod_start;
    logic                finish_fire;
    step_ctrl_t          step_ctrl;
    step_status_t        step_stat;
    mod_status_t         mod_stat;
    logic [COUNT_W-1:0]  count;

    assign in_fire = in_valid && !in_stall;

    cdd_mod400 u_mod400 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (earlier_year),
        .status (mod_stat)
    );

    cdd_step_unit u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (step_ctrl),
        .later_year    (later_year),
        .later_month   (later_month),
        .later_day     (later_day),
        .earlier_year  (earlier_year),
        .earlier_month (earlier_month),
        .earlier_day   (earlier_day),
        .rem           (mod_stat.rem),
        .status        (step_stat),
        .count         (count)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (mod_stat.done)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (!step_stat.is_before || step_stat.at_cap)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall          = (state_reg != ST_IDLE);
        mod_start         = in_valid && (state_reg == ST_IDLE);
        step_ctrl.load    = in_valid && (state_reg == ST_IDLE);
        step_ctrl.set_rem = (state_reg == ST_PREP) && mod_stat.done;
        step_ctrl.advance = (state_reg == ST_STEP) && step_stat.is_before && !step_stat.at_cap;
        finish_fire       = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        neg_next = neg_reg;
        if (in_fire)
            neg_next = date_before({1'b0, later_year}, later_month, later_day,
                                   {1'b0, earlier_year}, earlier_month, earlier_day);
    end

    // The output register frees once the result is taken, or is refilled in the same cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = neg_reg ? 16'shFFFF : signed'({1'b0, count});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign days_between = out_data_reg;

`ifndef ASSERT_OFF
    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && !step_stat.is_before) |=> (state_reg == ST_FINISH))
        else $error("stepping did not stop once the dates met");

    a_negative_only_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && days_between[15]) |-> (days_between == 16'shFFFF))
        else $error("negative day count other than minus one");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (mod_stat.rem <= REM_LAST))
        else $error("year remainder out of range");
`endif

endmodule

/* sv/cdd_mod400.sv */
// Iterative reducer that finds the year modulo 400 by repeated subtraction.
module cdd_mod400
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [IN_YEAR_W-1:0] value,
    output mod_status_t          status
);

    logic                 busy_reg, busy_next;
    logic [IN_YEAR_W-1:0] val_reg, val_next;
    logic                 below;

    assign below = (val_reg < MOD_BASE);

    always_comb
    begin
        busy_next = busy_reg;
        val_next  = val_reg;
        if (start)
        begin
            busy_next = 1'b1;
            val_next  = value;
        end
        else if (busy_reg)
        begin
            if (below)
                busy_next = 1'b0;
            else
                val_next = val_reg - MOD_BASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign status.done = busy_reg && below;
    assign status.rem  = val_reg[REM_W-1:0];

endmodule

/* sv/cdd_step_unit.sv */
// Date stepping datapath: advances the earlier date by one day per cycle and counts.
module cdd_step_unit
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  step_ctrl_t           ctrl,
    input  logic [IN_YEAR_W-1:0] later_year,
    input  logic [MONTH_W-1:0]   later_month,
    input  logic [DAY_W-1:0]     later_day,
    input  logic [IN_YEAR_W-1:0] earlier_year,
    input  logic [MONTH_W-1:0]   earlier_month,
    input  logic [DAY_W-1:0]     earlier_day,
    input  logic [REM_W-1:0]     rem,
    output step_status_t         status,
    output logic [COUNT_W-1:0]   count
);

    logic [IN_YEAR_W-1:0] ly_reg, ly_next;
    logic [MONTH_W-1:0]   lm_reg, lm_next;
    logic [DAY_W-1:0]     ld_reg, ld_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [REM_W-1:0]     r400_reg, r400_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 armed_reg;

    logic                 century;
    logic                 leap;
    logic [DAY_W:0]       day_inc;
    logic [MONTH_W:0]     month_inc;
    logic [DAY_W-1:0]     mlen;

    // The leap test runs off the tracked remainder, so no divider is needed.
    assign century = (r400_reg == 9'd0) || (r400_reg == 9'd100) ||
                     (r400_reg == 9'd200) || (r400_reg == 9'd300);
    assign leap    = ((year_reg[1:0] == 2'b00) && !century) || (r400_reg == 9'd0);
    assign mlen    = month_len(month_reg, leap);
    assign day_inc   = {1'b0, day_reg} + 6'd1;
    assign month_inc = {1'b0, month_reg} + 5'd1;

    always_comb
    begin
        ly_next    = ly_reg;
        lm_next    = lm_reg;
        ld_next    = ld_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        r400_next  = r400_reg;
        count_next = count_reg;
        if (ctrl.load)
        begin
            ly_next    = later_year;
            lm_next    = later_month;
            ld_next    = later_day;
            year_next  = {1'b0, earlier_year};
            month_next = earlier_month;
            day_next   = earlier_day;
            count_next = '0;
        end
        else if (ctrl.set_rem)
        begin
            r400_next = rem;
        end
        else if (ctrl.advance)
        begin
            count_next = count_reg + 15'd1;
            if (day_inc > {1'b0, mlen})
            begin
                day_next = 5'd1;
                if (month_inc > LAST_MONTH)
                begin
                    month_next = 4'd1;
                    year_next  = year_reg + 15'd1;
                    r400_next  = (r400_reg == REM_LAST) ? 9'd0 : r400_reg + 9'd1;
                end
                else
                begin
                    month_next = month_inc[MONTH_W-1:0];
                end
            end
            else
            begin
                day_next = day_inc[DAY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            armed_reg <= 1'b0;
        else if (ctrl.load)
            armed_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        ly_reg    <= ly_next;
        lm_reg    <= lm_next;
        ld_reg    <= ld_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        r400_reg  <= r400_next;
        count_reg <= count_next;
    end

    assign status.is_before = armed_reg &&
                              date_before(year_reg, month_reg, day_reg,
                                          {1'b0, ly_reg}, lm_reg, ld_reg);
    assign status.at_cap    = (count_reg == DAYS_CAP);
    assign count            = count_reg;

endmodule
